// File: rtl/core/life_pkg.sv
// ----------------------------------------------------------------------------
// life_pkg
// Shared types, sizes and helpers for the life automaton step block.
// ----------------------------------------------------------------------------
package life_pkg;

  // Board geometry
  localparam int ROWS  = 32;
  localparam int COLS  = 32;
  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int PW    = $clog2(COLS + 2);
  localparam int CNT_W = $clog2(CELLS + 1);

  // The 11-bit reported count fields saturate at this value
  localparam int COUNT_MAX = 2047;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_LOAD,
    S_LOAD2,
    S_SWEEP,
    S_ROWEND,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t        opcode;
    logic [4:0] row;
    logic [4:0] col;
    logic       alive;
  } in_item_t;

  typedef struct packed {
    logic        cell_value;
    logic [10:0] live_count;
    logic [10:0] births_step;
    logic [10:0] deaths_step;
    logic [31:0] births_total;
    logic [31:0] deaths_total;
    logic [31:0] steps_total;
  } out_item_t;

  // Verdict of the rule unit for one cell
  typedef struct packed {
    logic alive_next;
    logic born;
    logic died;
  } rule_res_t;

  // Clamp a board-wide count to the 11-bit report field
  function automatic logic [10:0] sat_count(input logic [CNT_W-1:0] v);
    logic [10:0] r;
    if (32'(v) > 32'(COUNT_MAX)) begin
      r = 11'h7ff;
    end else begin
      r = 11'(v);
    end
    return r;
  endfunction

  // Saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

endpackage

// File: rtl/core/life_automaton_step.sv
// ----------------------------------------------------------------------------
// life_automaton_step
// Game of Life board with cell access, clear and B3/S23 generation step.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on cmd and raise start; it is taken at an edge where
//   busy is low. Exactly one result follows on result, marked by done for
//   a single cycle; the receiver cannot stall it, so sample it then.
//   Steps from the accepting edge to the done cycle:
//     clear          : row flags dropped, then done
//     read, write    : one board row read, then write-back
//     generation step: rows swept in order by the single rule unit,
//                      which evaluates one cell per cycle within a row
//                      while the board row RAM streams rows in and out.
//   busy stays high from acceptance through the done cycle, so one item is
//   in flight at a time; the next can be taken the cycle after done.
//   The board is a RAM of ROWS words of COLS bits with one valid flag per
//   row; reset and clear drop the flags, so the board reads dead at once
//   with no clearing pass. Reset also zeroes all reported counters.
// ----------------------------------------------------------------------------
module life_automaton_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  life_pkg::in_item_t  cmd,
  output logic                busy,
  output logic                done,
  output life_pkg::out_item_t result
);

  life_pkg::state_t  state, state_next;
  life_pkg::in_item_t cmd_q;

  logic [life_pkg::ROWS-1:0]  row_valid;
  logic                       rd_valid;
  logic [life_pkg::RW-1:0]    ram_raddr;
  logic [life_pkg::RW-1:0]    ram_waddr;
  logic [life_pkg::COLS-1:0]  ram_wdata;
  logic [life_pkg::COLS-1:0]  ram_rdata;
  logic                       ram_we;
  logic [life_pkg::COLS-1:0]  row_data;

  logic [life_pkg::COLS-1:0]  prev_row, cur_row, next_row, new_row;
  logic [life_pkg::RW-1:0]    r;
  logic [life_pkg::CW-1:0]    c;
  logic [life_pkg::CNT_W-1:0] born_cnt, died_cnt, live;
  logic [10:0]                births_last, deaths_last;
  logic [31:0]                births_sum, deaths_sum, step_count;
  logic                       cell_q;

  logic                       accept;
  logic                       on_board;
  logic                       is_write;
  logic [life_pkg::RW-1:0]    row_i;
  logic [life_pkg::CW-1:0]    col_i;
  logic                       old_bit;
  logic [life_pkg::COLS-1:0]  merged_row;
  logic [life_pkg::COLS+1:0]  pad_prev, pad_cur, pad_next;
  logic [life_pkg::PW-1:0]    win;
  life_pkg::rule_res_t        res;
  logic                       last_col, last_row;
  logic [life_pkg::CNT_W:0]   live_step;

  // Board row storage
  life_ram #(
    .WIDTH (life_pkg::COLS),
    .DEPTH (life_pkg::ROWS)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Track row validity alongside the registered read
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[ram_raddr];
  end

  // Decode the held item and the current row
  always_comb begin
    row_data   = ram_rdata & {life_pkg::COLS{rd_valid}};
    row_i      = life_pkg::RW'(cmd_q.row);
    col_i      = life_pkg::CW'(cmd_q.col);
    on_board   = (32'(cmd_q.row) < 32'(life_pkg::ROWS))
              && (32'(cmd_q.col) < 32'(life_pkg::COLS));
    is_write   = (cmd_q.opcode == life_pkg::OP_WRITE);
    old_bit    = row_data[col_i];
    merged_row = row_data;
    merged_row[col_i] = cmd_q.alive;
    last_col   = (c == life_pkg::CW'(life_pkg::COLS - 1));
    last_row   = (r == life_pkg::RW'(life_pkg::ROWS - 1));
    live_step  = ({1'b0, live} + (life_pkg::CNT_W + 1)'(born_cnt))
               - (life_pkg::CNT_W + 1)'(died_cnt);
  end

  // Pad rows with dead cells at both edges and pick the 3x3 window
  always_comb begin
    pad_prev = {1'b0, prev_row, 1'b0};
    pad_cur  = {1'b0, cur_row, 1'b0};
    pad_next = {1'b0, next_row, 1'b0};
    win      = life_pkg::PW'(c);
  end

  life_rule u_rule (
    .above  (pad_prev[win +: 3]),
    .middle (pad_cur[win +: 3]),
    .below  (pad_next[win +: 3]),
    .res    (res)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= life_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    ram_raddr  = life_pkg::RW'(cmd.row);
    ram_we     = 1'b0;
    ram_waddr  = r;
    ram_wdata  = new_row;
    unique case (state)
      life_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            life_pkg::OP_WRITE, life_pkg::OP_READ: begin
              state_next = life_pkg::S_CELL;
            end
            life_pkg::OP_STEP: begin
              ram_raddr  = '0;
              state_next = life_pkg::S_LOAD;
            end
            life_pkg::OP_CLEAR: begin
              state_next = life_pkg::S_FINISH;
            end
            default: state_next = life_pkg::S_IDLE;
          endcase
        end
      end
      life_pkg::S_CELL: begin
        ram_we     = is_write && on_board;
        ram_waddr  = row_i;
        ram_wdata  = merged_row;
        state_next = life_pkg::S_FINISH;
      end
      life_pkg::S_LOAD: begin
        ram_raddr  = life_pkg::RW'(1);
        state_next = life_pkg::S_LOAD2;
      end
      life_pkg::S_LOAD2: begin
        state_next = life_pkg::S_SWEEP;
      end
      life_pkg::S_SWEEP: begin
        if (last_col) begin
          state_next = life_pkg::S_ROWEND;
        end
      end
      life_pkg::S_ROWEND: begin
        ram_we     = 1'b1;
        ram_raddr  = r + life_pkg::RW'(2);
        state_next = last_row ? life_pkg::S_FINISH : life_pkg::S_SHIFT;
      end
      life_pkg::S_SHIFT: begin
        state_next = life_pkg::S_SWEEP;
      end
      life_pkg::S_FINISH: begin
        state_next = life_pkg::S_IDLE;
      end
      default: state_next = life_pkg::S_IDLE;
    endcase
  end

  // Counters, row flags and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      live        <= '0;
      births_last <= '0;
      deaths_last <= '0;
      births_sum  <= '0;
      deaths_sum  <= '0;
      step_count  <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == life_pkg::S_FINISH);
      unique case (state)
        life_pkg::S_IDLE: begin
          // Drop all rows at once on clear
          if (accept && (cmd.opcode == life_pkg::OP_CLEAR)) begin
            row_valid <= '0;
            live      <= '0;
          end
        end
        life_pkg::S_CELL: begin
          // Adjust the live count by the change of the written cell
          if (is_write && on_board) begin
            row_valid[row_i] <= 1'b1;
            if (cmd_q.alive && !old_bit) begin
              live <= live + life_pkg::CNT_W'(1);
            end else if (!cmd_q.alive && old_bit) begin
              live <= live - life_pkg::CNT_W'(1);
            end
          end
        end
        life_pkg::S_ROWEND: begin
          row_valid[r] <= 1'b1;
        end
        life_pkg::S_FINISH: begin
          // Fold the step tallies into the totals
          if (cmd_q.opcode == life_pkg::OP_STEP) begin
            live        <= life_pkg::CNT_W'(live_step);
            births_last <= life_pkg::sat_count(born_cnt);
            deaths_last <= life_pkg::sat_count(died_cnt);
            births_sum  <= life_pkg::sat_add(births_sum, 32'(born_cnt));
            deaths_sum  <= life_pkg::sat_add(deaths_sum, 32'(died_cnt));
            step_count  <= life_pkg::sat_add(step_count, 32'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Item capture and sweep datapath
  always_ff @(posedge clk) begin
    unique case (state)
      life_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q    <= cmd;
          cell_q   <= 1'b0;
          born_cnt <= '0;
          died_cnt <= '0;
          r        <= '0;
          prev_row <= '0;
        end
      end
      life_pkg::S_CELL: begin
        if (on_board) begin
          cell_q <= is_write ? cmd_q.alive : old_bit;
        end
      end
      life_pkg::S_LOAD: begin
        cur_row <= row_data;
      end
      life_pkg::S_LOAD2: begin
        next_row <= row_data;
        c        <= '0;
      end
      life_pkg::S_SWEEP: begin
        // Evaluate one cell per cycle
        new_row[c] <= res.alive_next;
        born_cnt   <= born_cnt + life_pkg::CNT_W'(res.born);
        died_cnt   <= died_cnt + life_pkg::CNT_W'(res.died);
        if (on_board && (r == row_i) && (c == col_i)) begin
          cell_q <= res.alive_next;
        end
        c <= c + life_pkg::CW'(1);
      end
      life_pkg::S_ROWEND: begin
        // Slide the three-row window down
        prev_row <= cur_row;
        cur_row  <= next_row;
        r        <= r + life_pkg::RW'(1);
      end
      life_pkg::S_SHIFT: begin
        next_row <= ((32'(r) + 32'd1) < 32'(life_pkg::ROWS)) ? row_data : '0;
        c        <= '0;
      end
      default: ;
    endcase
  end

  // Present the result from the held state
  always_comb begin
    busy                = (state != life_pkg::S_IDLE) || done;
    accept              = start && !busy;
    result.cell_value   = cell_q;
    result.live_count   = life_pkg::sat_count(live);
    result.births_step  = births_last;
    result.deaths_step  = deaths_last;
    result.births_total = births_sum;
    result.deaths_total = deaths_sum;
    result.steps_total  = step_count;
  end

`ifndef SYNTH
  // An accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  // Live count never exceeds the board size
  a_live_range: assert property (@(posedge clk) disable iff (rst)
    32'(live) <= 32'(life_pkg::CELLS))
    else $error("live count out of range");

  // A clear reports an empty board and a dead cell
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (cmd_q.opcode == life_pkg::OP_CLEAR))
      |-> ((result.live_count == 11'd0) && !result.cell_value))
    else $error("clear left live cells");

  // The step counter moves only on a finished generation step
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (step_count != $past(step_count))
      |-> (done && (cmd_q.opcode == life_pkg::OP_STEP)))
    else $error("step counter changed outside a step");
`endif

endmodule

// File: rtl/core/life_ram.sv
// ----------------------------------------------------------------------------
// life_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module life_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/life_rule.sv
// ----------------------------------------------------------------------------
// life_rule
// Shared cell unit: counts the eight neighbours and applies rule B3/S23.
// ----------------------------------------------------------------------------
module life_rule (
  input  logic [2:0]           above,
  input  logic [2:0]           middle,
  input  logic [2:0]           below,
  output life_pkg::rule_res_t  res
);

  logic [3:0] nbr;
  logic       cur;

  // Count live neighbours; the middle bit of the middle window is the cell
  always_comb begin
    cur = middle[1];
    nbr = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
        + 4'(middle[0]) + 4'(middle[2])
        + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
  end

  // Survive on two or three, birth on exactly three
  always_comb begin
    res.alive_next = (nbr == 4'd3) || (cur && (nbr == 4'd2));
    res.born       = !cur && (nbr == 4'd3);
    res.died       = cur && (nbr != 4'd2) && (nbr != 4'd3);
  end

endmodule
